FILE: hw/rtl/reliable_transfer_receive_tracker_top_macros.svh
// ----------------------------------------------------------------------------
// Reliable transfer receive tracker assertion macros
// Shared assertion forms for the tracker. They compile away when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef RELIABLE_TRANSFER_RECEIVE_TRACKER_TOP_MACROS_SVH
`define RELIABLE_TRANSFER_RECEIVE_TRACKER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RTRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tracker assertion failed");
`define RTRT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tracker assertion failed");
`else
`define RTRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RTRT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/rtrt_pkg.sv
// ----------------------------------------------------------------------------
// Receive tracker package
// Widths, flag codes, status codes and the controller to datapath interface.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rtrt_pkg;

    localparam int FLAGS_W      = 16;
    localparam int SEQ_W        = 16;
    localparam int LEN_W        = 32;
    localparam int SEG_BYTES_W  = 16;
    localparam int STATUS_W     = 3;
    localparam int ACK_FLAGS_W  = 8;
    localparam int SEG_LEFT_W   = 11;
    localparam int DIVIDEND_W   = LEN_W + 1;
    localparam int DIV_STEPS    = DIVIDEND_W;
    localparam int S_TDATA_W    = 48;
    localparam int M_TDATA_W    = 40;
    localparam int M_FIELDS_W   = 1 + ACK_FLAGS_W + SEQ_W + 1 + SEG_LEFT_W;
    localparam int M_PAD_W      = M_TDATA_W - M_FIELDS_W;

    localparam int DEFAULT_MAX_SEGMENTS = 1024;

    localparam logic [FLAGS_W-1:0] FLAG_LEN = 16'h0040;
    localparam logic [FLAGS_W-1:0] FLAG_ACK = 16'h0010;
    localparam logic [FLAGS_W-1:0] FLAG_MSG = 16'h0008;

    localparam logic [ACK_FLAGS_W-1:0] ACK_LEN_FLAGS = ACK_FLAGS_W'(FLAG_LEN | FLAG_ACK);
    localparam logic [ACK_FLAGS_W-1:0] ACK_MSG_FLAGS = ACK_FLAGS_W'(FLAG_MSG | FLAG_ACK);

    localparam logic [SEG_BYTES_W-1:0] DEFAULT_SEG_BYTES = 16'd1024;

    localparam logic [STATUS_W-1:0] ST_DROP     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_LEN_OK   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SEG_OK   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd4;

    typedef enum logic [2:0] {
        K_DROP,
        K_LEN,
        K_MSG,
        K_RANGE,
        K_LONG
    } t_kind;

    typedef struct packed {
        logic  capture;
        logic  div_start;
        logic  load_count;
        logic  clr_step;
        logic  mem_read;
        logic  mark;
        logic  load_result;
        t_kind kind;
    } t_cmd;

    typedef struct packed {
        logic is_len;
        logic is_msg;
        logic phase;
        logic in_range;
        logic div_done;
        logic too_long;
        logic count_zero;
        logic clr_last;
        logic out_free;
    } t_stat;

endpackage

FILE: hw/rtl/rtrt_div.sv
// ----------------------------------------------------------------------------
// Receive tracker divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtrt_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [rtrt_pkg::DIVIDEND_W-1:0]  i_dividend,
    input  logic [rtrt_pkg::SEG_BYTES_W-1:0] i_divisor,
    output logic                             o_done,
    output logic [rtrt_pkg::DIVIDEND_W-1:0]  o_quotient
);
    import rtrt_pkg::*;

    localparam int STEP_W = $clog2(DIV_STEPS);

    logic                   r_busy;
    logic                   r_done;
    logic [STEP_W-1:0]      r_step;
    logic [SEG_BYTES_W-1:0] r_rem;
    logic [SEG_BYTES_W-1:0] r_div;
    logic [DIVIDEND_W-1:0]  r_q;

    logic [SEG_BYTES_W:0]   trial;
    logic [SEG_BYTES_W:0]   diff;
    logic                   q_bit;
    logic [SEG_BYTES_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_q[DIVIDEND_W-1]};
        diff  = trial - {1'b0, r_div};
        q_bit = (trial >= {1'b0, r_div});
        n_rem = q_bit ? diff[SEG_BYTES_W-1:0] : trial[SEG_BYTES_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= {r_q[DIVIDEND_W-2:0], q_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

FILE: hw/rtl/rtrt_dp.sv
// ----------------------------------------------------------------------------
// Receive tracker datapath
// Holds the captured header, the segment counters, the confirmation map,
// the segment size register and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtrt_dp #(
    parameter int MAX_SEGMENTS = rtrt_pkg::DEFAULT_MAX_SEGMENTS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [rtrt_pkg::SEG_BYTES_W-1:0] i_cfg_wr_data,
    input  logic [rtrt_pkg::FLAGS_W-1:0]     i_flags,
    input  logic [rtrt_pkg::SEQ_W-1:0]       i_seq,
    input  logic [rtrt_pkg::LEN_W-1:0]       i_len,
    input  rtrt_pkg::t_cmd                   i_cmd,
    output rtrt_pkg::t_stat                  o_stat,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [rtrt_pkg::STATUS_W-1:0]    o_status,
    output logic                             o_ack_valid,
    output logic [rtrt_pkg::ACK_FLAGS_W-1:0] o_ack_flags,
    output logic [rtrt_pkg::SEQ_W-1:0]       o_ack_seq,
    output logic                             o_complete,
    output logic [rtrt_pkg::SEG_LEFT_W-1:0]  o_segments_left
);
    import rtrt_pkg::*;

    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int AW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CMP_W = SEQ_W + 1;

    logic [SEG_BYTES_W-1:0] r_seg_bytes;
    logic [FLAGS_W-1:0]     r_flags;
    logic [SEQ_W-1:0]       r_seq;
    logic [LEN_W-1:0]       r_len;
    logic                   r_phase;
    logic [CNT_W-1:0]       r_seg_count;
    logic [CNT_W-1:0]       r_conf_count;
    logic [AW-1:0]          r_clr_ptr;
    logic                   r_rd_bit;
    logic                   r_map [MAX_SEGMENTS];

    logic                   r_out_valid;
    logic [STATUS_W-1:0]    r_status;
    logic                   r_ack_valid;
    logic [ACK_FLAGS_W-1:0] r_ack_flags;
    logic [SEQ_W-1:0]       r_ack_seq;
    logic                   r_complete;
    logic [SEG_LEFT_W-1:0]  r_left;

    logic [SEG_BYTES_W-1:0] seg_eff;
    logic [DIVIDEND_W-1:0]  dividend;
    logic                   div_done;
    logic [DIVIDEND_W-1:0]  quotient;
    logic [CNT_W-1:0]       cnt_diff;
    logic                   all_confirmed;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic                   wr_bit;

    logic [STATUS_W-1:0]    n_status;
    logic                   n_ack_valid;
    logic [ACK_FLAGS_W-1:0] n_ack_flags;
    logic [SEQ_W-1:0]       n_ack_seq;
    logic                   n_complete;
    logic [CNT_W-1:0]       n_left;

    // A zero segment size counts as the default size.
    assign seg_eff  = (r_seg_bytes == '0) ? DEFAULT_SEG_BYTES : r_seg_bytes;
    assign dividend = DIVIDEND_W'(r_len) + DIVIDEND_W'(seg_eff) - DIVIDEND_W'(1);

    rtrt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (seg_eff),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign cnt_diff      = r_seg_count - r_conf_count;
    assign all_confirmed = (r_conf_count == r_seg_count);

    always_comb begin
        o_stat.is_len     = (r_flags == FLAG_LEN);
        o_stat.is_msg     = (r_flags == FLAG_MSG);
        o_stat.phase      = r_phase;
        o_stat.in_range   = (CMP_W'(r_seq) < CMP_W'(r_seg_count));
        o_stat.div_done   = div_done;
        o_stat.too_long   = (quotient > DIVIDEND_W'(MAX_SEGMENTS));
        o_stat.count_zero = (quotient == '0);
        o_stat.clr_last   = (CNT_W'(r_clr_ptr) == r_seg_count - CNT_W'(1));
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    always_comb begin
        wr_en   = i_cmd.clr_step || (i_cmd.mark && !r_rd_bit);
        wr_addr = i_cmd.clr_step ? r_clr_ptr : r_seq[AW-1:0];
        wr_bit  = !i_cmd.clr_step;
    end

    always_comb begin
        n_status    = ST_DROP;
        n_ack_valid = 1'b0;
        n_ack_flags = '0;
        n_ack_seq   = '0;
        n_complete  = 1'b0;
        n_left      = r_phase ? cnt_diff : '0;
        case (i_cmd.kind)
            K_DROP: begin
                n_status = ST_DROP;
            end
            K_LEN: begin
                n_status    = ST_LEN_OK;
                n_ack_valid = 1'b1;
                n_ack_flags = ACK_LEN_FLAGS;
                n_complete  = (r_seg_count == '0);
            end
            K_MSG: begin
                n_status    = ST_SEG_OK;
                n_ack_valid = 1'b1;
                n_ack_flags = ACK_MSG_FLAGS;
                n_ack_seq   = r_seq;
                n_complete  = all_confirmed;
                if (all_confirmed) begin
                    n_left = '0;
                end
            end
            K_RANGE: begin
                n_status = ST_RANGE;
            end
            K_LONG: begin
                n_status = ST_TOO_LONG;
            end
            default: begin
                n_status = ST_DROP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_bytes  <= DEFAULT_SEG_BYTES;
            r_phase      <= 1'b0;
            r_seg_count  <= '0;
            r_conf_count <= '0;
            r_clr_ptr    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_seg_bytes <= i_cfg_wr_data;
            end
            if (i_cmd.load_count) begin
                r_seg_count  <= CNT_W'(quotient);
                r_conf_count <= '0;
                r_clr_ptr    <= '0;
                r_phase      <= (quotient != '0);
            end
            if (i_cmd.clr_step) begin
                r_clr_ptr <= r_clr_ptr + AW'(1);
            end
            if (i_cmd.mark && !r_rd_bit) begin
                r_conf_count <= r_conf_count + CNT_W'(1);
            end
            if (i_cmd.load_result && i_cmd.kind == K_MSG && all_confirmed) begin
                r_phase <= 1'b0;
            end
            if (i_cmd.load_result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_flags <= i_flags;
            r_seq   <= i_seq;
            r_len   <= i_len;
        end
        if (i_cmd.load_result) begin
            r_status    <= n_status;
            r_ack_valid <= n_ack_valid;
            r_ack_flags <= n_ack_flags;
            r_ack_seq   <= n_ack_seq;
            r_complete  <= n_complete;
            r_left      <= SEG_LEFT_W'(n_left);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_map[wr_addr] <= wr_bit;
        end
        if (i_cmd.mem_read) begin
            r_rd_bit <= r_map[r_seq[AW-1:0]];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_ack_valid     = r_ack_valid;
    assign o_ack_flags     = r_ack_flags;
    assign o_ack_seq       = r_ack_seq;
    assign o_complete      = r_complete;
    assign o_segments_left = r_left;

endmodule

FILE: hw/rtl/rtrt_ctrl.sv
// ----------------------------------------------------------------------------
// Receive tracker controller
// Sequences header decode, division, map clearing, map update and result
// hand-off for one packet at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtrt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  rtrt_pkg::t_stat i_stat,
    output rtrt_pkg::t_cmd  o_cmd
);
    import rtrt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_CLEAR,
        S_READ,
        S_MARK,
        S_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;
    t_kind  r_kind;
    t_kind  n_kind;

    always_comb begin
        n_state           = r_state;
        n_kind            = r_kind;
        o_cmd             = '0;
        o_cmd.kind        = r_kind;
        o_in_ready        = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_stat.phase) begin
                    if (i_stat.is_len) begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end else begin
                        n_kind  = K_DROP;
                        n_state = S_RESULT;
                    end
                end else if (!i_stat.is_msg) begin
                    n_kind  = K_DROP;
                    n_state = S_RESULT;
                end else if (!i_stat.in_range) begin
                    n_kind  = K_RANGE;
                    n_state = S_RESULT;
                end else begin
                    n_state = S_READ;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    if (i_stat.too_long) begin
                        n_kind  = K_LONG;
                        n_state = S_RESULT;
                    end else begin
                        o_cmd.load_count = 1'b1;
                        n_kind           = K_LEN;
                        n_state          = i_stat.count_zero ? S_RESULT : S_CLEAR;
                    end
                end
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_RESULT;
                end
            end
            S_READ: begin
                o_cmd.mem_read = 1'b1;
                n_state        = S_MARK;
            end
            S_MARK: begin
                o_cmd.mark = 1'b1;
                n_kind     = K_MSG;
                n_state    = S_RESULT;
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_result = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= K_DROP;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

endmodule

FILE: hw/rtl/reliable_transfer_receive_tracker_top.sv
// ----------------------------------------------------------------------------
// Reliable transfer receive tracker
// Receive-side tracker of a selective-repeat transfer: takes one parsed
// packet header per transfer and returns one result transfer per header.
// ----------------------------------------------------------------------------
// The block handles one header at a time and can take the next one while the
// previous result still waits at the output. A dropped or out-of-range header
// goes from decode straight to the result; a message header first reads and
// then updates the confirmation map. For a length header the segment count
// comes from a divider that retires one quotient bit per cycle for a 33-bit
// quotient, and the map entries of the new message are then cleared one per
// cycle. The segment size register may be written only while the block is
// idle; a size of zero counts as 1024 bytes.
`timescale 1ns / 1ps

`include "reliable_transfer_receive_tracker_top_macros.svh"

module reliable_transfer_receive_tracker_top #(
    parameter int MAX_SEGMENTS = rtrt_pkg::DEFAULT_MAX_SEGMENTS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [rtrt_pkg::SEG_BYTES_W-1:0] i_cfg_wr_data,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // seq_number, message_length
    input  logic [rtrt_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // flags
    input  logic [rtrt_pkg::FLAGS_W-1:0]     i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // ack_valid, ack_flags, ack_seq, message_complete, segments_left, zero pad
    output logic [rtrt_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    // status
    output logic [rtrt_pkg::STATUS_W-1:0]    o_m_axis_tuser
);
    import rtrt_pkg::*;

    t_cmd                   cmd;
    t_stat                  stat;
    logic                   ack_valid;
    logic [ACK_FLAGS_W-1:0] ack_flags;
    logic [SEQ_W-1:0]       ack_seq;
    logic                   complete;
    logic [SEG_LEFT_W-1:0]  segments_left;

    rtrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rtrt_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_flags         (i_s_axis_tuser),
        .i_seq           (i_s_axis_tdata[SEQ_W-1:0]),
        .i_len           (i_s_axis_tdata[SEQ_W +: LEN_W]),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_out_ready     (i_m_axis_tready),
        .o_out_valid     (o_m_axis_tvalid),
        .o_status        (o_m_axis_tuser),
        .o_ack_valid     (ack_valid),
        .o_ack_flags     (ack_flags),
        .o_ack_seq       (ack_seq),
        .o_complete      (complete),
        .o_segments_left (segments_left)
    );

    assign o_m_axis_tdata = {{M_PAD_W{1'b0}}, segments_left, complete, ack_seq,
                             ack_flags, ack_valid};

    `RTRT_ASSERT_NXT(a_one_at_a_time, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)
    `RTRT_ASSERT_IMP(a_valid_from_load, i_clk, i_rst_n, $rose(o_m_axis_tvalid), $past(cmd.load_result))
    `RTRT_ASSERT_IMP(a_ack_status, i_clk, i_rst_n, o_m_axis_tvalid && ack_valid, o_m_axis_tuser == ST_LEN_OK || o_m_axis_tuser == ST_SEG_OK)
    `RTRT_ASSERT_IMP(a_complete_left, i_clk, i_rst_n, o_m_axis_tvalid && complete, segments_left == '0)

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// Receive tracker testbench
// Sends packet headers to the tracker, predicts each result with a
// cycle-free model of the phase, the confirmation map and the counters,
// and compares every result transfer field by field. Both stream sides
// idle at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import rtrt_pkg::*;

    localparam int unsigned IDLE_LIMIT = 6000;
    localparam int unsigned LONG_HOLD  = 400;

    typedef struct packed {
        logic [FLAGS_W-1:0] flags;
        logic [SEQ_W-1:0]   seq;
        logic [LEN_W-1:0]   len;
    } t_hdr;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic                   ack_valid;
        logic [ACK_FLAGS_W-1:0] ack_flags;
        logic [SEQ_W-1:0]       ack_seq;
        logic                   done;
        logic [SEG_LEFT_W-1:0]  left;
    } t_ack_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [SEG_BYTES_W-1:0] cfg_wr_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [FLAGS_W-1:0]     s_tuser = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]    m_tuser;

    reliable_transfer_receive_tracker_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    // Model state of the tracker.
    logic [SEG_BYTES_W-1:0]        seg_size = DEFAULT_SEG_BYTES;
    bit                            rx_active = 1'b0;
    bit [DEFAULT_MAX_SEGMENTS-1:0] seen_map = '0;
    logic [SEG_LEFT_W-1:0]         seg_total = '0;
    logic [SEG_LEFT_W-1:0]         seg_done = '0;

    t_hdr          pending_hdrs[$];
    t_ack_result   expected_acks[$];
    int unsigned   hdrs_sent = 0;
    int unsigned   hdrs_accepted = 0;
    int unsigned   hdrs_queued = 0;
    int unsigned   mismatches = 0;
    int unsigned   idle_cycles = 0;
    int unsigned   hold_requests = 0;
    int unsigned   hold_served = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_ack_result track_header(input t_hdr h);
        t_ack_result     r;
        longint unsigned size;
        longint unsigned count;
        r = '0;
        if (!rx_active) begin
            if (h.flags != FLAG_LEN) begin
                return r;
            end
            size = (seg_size == 0) ? 64'd1024 : {48'd0, seg_size};
            count = ({32'd0, h.len} + size - 1) / size;
            if (count > DEFAULT_MAX_SEGMENTS) begin
                r.status = ST_TOO_LONG;
                return r;
            end
            seen_map = '0;
            seg_total = count[SEG_LEFT_W-1:0];
            seg_done = '0;
            r.status = ST_LEN_OK;
            r.ack_valid = 1'b1;
            r.ack_flags = ACK_LEN_FLAGS;
            if (count == 0) begin
                r.done = 1'b1;
            end else begin
                rx_active = 1'b1;
                r.left = seg_total;
            end
            return r;
        end
        r.left = seg_total - seg_done;
        if (h.flags != FLAG_MSG) begin
            r.status = ST_DROP;
            return r;
        end
        if ({16'd0, h.seq} >= {21'd0, seg_total}) begin
            r.status = ST_RANGE;
            return r;
        end
        if (!seen_map[h.seq]) begin
            seen_map[h.seq] = 1'b1;
            seg_done = seg_done + 1'b1;
        end
        r.status = ST_SEG_OK;
        r.ack_valid = 1'b1;
        r.ack_flags = ACK_MSG_FLAGS;
        r.ack_seq = h.seq;
        if (seg_done == seg_total) begin
            rx_active = 1'b0;
            r.done = 1'b1;
            r.left = '0;
        end else begin
            r.left = seg_total - seg_done;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_result();
        t_ack_result want;
        if (expected_acks.size() == 0) begin
            report_mismatch("result with no header pending", m_tdata, 0);
            return;
        end
        want = expected_acks.pop_front();
        if (m_tuser != want.status)
            report_mismatch("status", m_tuser, want.status);
        if (m_tdata[0] != want.ack_valid)
            report_mismatch("ack_valid", m_tdata[0], want.ack_valid);
        if (m_tdata[8:1] != want.ack_flags)
            report_mismatch("ack_flags", m_tdata[8:1], want.ack_flags);
        if (m_tdata[24:9] != want.ack_seq)
            report_mismatch("ack_seq", m_tdata[24:9], want.ack_seq);
        if (m_tdata[25] != want.done)
            report_mismatch("message_complete", m_tdata[25], want.done);
        if (m_tdata[36:26] != want.left)
            report_mismatch("segments_left", m_tdata[36:26], want.left);
    endtask

    // Monitor, predictor and watchdog.
    always @(posedge i_clk) begin
        bit          moved;
        t_ack_result pred;
        moved = 1'b0;
        if (i_rst_n) begin
            if (m_valid && m_ready) begin
                moved = 1'b1;
                check_result();
            end
            if (s_valid && s_ready) begin
                moved = 1'b1;
                hdrs_accepted++;
                pred = track_header({s_tuser, s_tdata[15:0], s_tdata[47:16]});
                expected_acks = {expected_acks, pred};
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("reliable_transfer_receive_tracker_top: mismatch");
                $finish;
            end
        end
    end

    task automatic roll_mode(inout int unsigned left, inout bit calm);
        if (left == 0) begin
            calm = ($urandom_range(0, 1) == 1);
            left = $urandom_range(20, 60);
        end else begin
            left--;
        end
    endtask

    function automatic int unsigned pick_idle(input bit calm);
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Header driver.
    always @(negedge i_clk) begin
        t_hdr        h;
        int unsigned tx_gap;
        int unsigned tx_mode_left;
        bit          tx_calm;
        if (i_rst_n && hdrs_sent == hdrs_accepted) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_valid <= 1'b0;
            end else if (pending_hdrs.size() > 0) begin
                h = pending_hdrs.pop_front();
                s_valid <= 1'b1;
                s_tuser <= h.flags;
                s_tdata <= {h.len, h.seq};
                hdrs_sent++;
                roll_mode(tx_mode_left, tx_calm);
                tx_gap = pick_idle(tx_calm);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver.
    always @(negedge i_clk) begin
        int unsigned rx_hold;
        int unsigned rx_mode_left;
        bit          rx_calm;
        int unsigned stall;
        if (i_rst_n) begin
            if (hold_served != hold_requests) begin
                hold_served++;
                rx_hold = LONG_HOLD;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_ready <= 1'b0;
            end else begin
                roll_mode(rx_mode_left, rx_calm);
                stall = pick_idle(rx_calm);
                if (stall > 0) begin
                    rx_hold = stall - 1;
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        end
    end

    task automatic push_hdr(input logic [FLAGS_W-1:0] flags, input logic [SEQ_W-1:0] seq,
                            input logic [LEN_W-1:0] len);
        t_hdr h;
        h.flags = flags;
        h.seq = seq;
        h.len = len;
        pending_hdrs = {pending_hdrs, h};
        hdrs_queued++;
    endtask

    task automatic push_noise_receiving(input int unsigned n);
        case ($urandom_range(0, 3))
            0: push_hdr(FLAGS_W'($urandom_range(0, 65535)), SEQ_W'($urandom_range(0, 65535)),
                        $urandom());
            1: push_hdr(FLAG_LEN, SEQ_W'($urandom_range(0, 65535)), $urandom());
            2: push_hdr(FLAG_MSG, SEQ_W'($urandom_range(n, 65535)), $urandom());
            default: push_hdr(FLAG_MSG | FLAG_ACK, SEQ_W'($urandom_range(0, n - 1)), 0);
        endcase
    endtask

    task automatic push_noise_waiting();
        longint unsigned size;
        size = (seg_size == 0) ? 1024 : seg_size;
        case ($urandom_range(0, 2))
            0: push_hdr(FLAG_MSG, SEQ_W'($urandom_range(0, 65535)), $urandom());
            1: push_hdr(FLAG_LEN, 0, LEN_W'(size * DEFAULT_MAX_SEGMENTS
                                            + $urandom_range(1, size)));
            default: begin
                push_hdr(FLAGS_W'($urandom_range(0, 65535)) & ~FLAG_LEN,
                         SEQ_W'($urandom_range(0, 65535)), $urandom());
            end
        endcase
    endtask

    task automatic push_message(input int unsigned n);
        int unsigned     order[$];
        int unsigned     i;
        int unsigned     j;
        int unsigned     tmp;
        longint unsigned size;
        size = (seg_size == 0) ? 1024 : seg_size;
        if (n == 0) begin
            push_hdr(FLAG_LEN, SEQ_W'($urandom_range(0, 65535)), 0);
            return;
        end
        push_hdr(FLAG_LEN, SEQ_W'($urandom_range(0, 65535)),
                 LEN_W'((n - 1) * size + $urandom_range(1, size)));
        for (i = 0; i < n; i++)
            order = {order, i};
        for (i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (i = 0; i < n; i++) begin
            push_hdr(FLAG_MSG, SEQ_W'(order[i]), $urandom());
            if ($urandom_range(0, 99) < 10)
                push_hdr(FLAG_MSG, SEQ_W'(order[$urandom_range(0, i)]), $urandom());
            if (i + 1 < n && $urandom_range(0, 99) < 12)
                push_noise_receiving(n);
        end
    endtask

    task automatic push_random_phase(input int unsigned count);
        int unsigned start;
        int unsigned r;
        start = hdrs_queued;
        while (hdrs_queued - start < count) begin
            if ($urandom_range(0, 99) < 15)
                push_noise_waiting();
            r = $urandom_range(0, 99);
            if (r < 70)
                push_message($urandom_range(1, 6));
            else if (r < 92)
                push_message($urandom_range(7, 40));
            else if (r < 97)
                push_message(0);
            else
                push_message($urandom_range(41, 200));
        end
    endtask

    task automatic wait_drained();
        while (pending_hdrs.size() > 0 || hdrs_sent != hdrs_accepted
               || expected_acks.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_seg_size(input logic [SEG_BYTES_W-1:0] v);
        @(negedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        seg_size = v;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed headers at the reset segment size of 1024 bytes.
        push_hdr(FLAG_MSG, 0, 0);
        push_hdr(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        push_hdr(FLAG_LEN, 0, 0);
        push_hdr(FLAG_LEN, 0, 32'hFFFF_FFFF);
        push_hdr(FLAG_LEN, 0, 32'd1048577);
        push_hdr(FLAG_LEN, 0, 32'd2049);
        push_hdr(FLAG_LEN, 0, 32'd5);
        push_hdr(FLAG_MSG, 3, 0);
        push_hdr(FLAG_MSG, 16'hFFFF, 0);
        push_hdr(FLAG_MSG | FLAG_ACK, 0, 0);
        push_hdr(FLAG_MSG, 1, 0);
        push_hdr(FLAG_MSG, 1, 0);
        push_hdr(FLAG_MSG, 0, 0);
        push_hdr(FLAG_MSG, 2, 0);
        push_hdr(FLAG_MSG, 2, 0);
        push_hdr(FLAG_LEN, 0, 32'd1024);
        push_hdr(FLAG_MSG, 0, 0);
        wait_drained();

        // A zero size counts as 1024 bytes.
        write_seg_size(16'd0);
        push_random_phase(110);
        wait_drained();

        write_seg_size(16'd1);
        push_random_phase(100);
        wait_drained();

        write_seg_size(16'hFFFF);
        push_random_phase(100);
        wait_drained();

        // The result side holds off while headers keep coming.
        write_seg_size(16'($urandom_range(2, 65534)));
        push_random_phase(110);
        hold_requests++;
        wait_drained();

        // The largest message and the first length beyond it.
        write_seg_size(16'd1);
        push_hdr(FLAG_LEN, 0, 32'd1025);
        push_hdr(FLAG_LEN, 0, 32'd1024);
        push_hdr(FLAG_MSG, 16'd1023, 0);
        push_hdr(FLAG_MSG, 16'd1024, 0);
        push_hdr(FLAG_MSG, 16'd0, 0);
        wait_drained();

        repeat (60) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("reliable_transfer_receive_tracker_top: match");
        end else begin
            $display("reliable_transfer_receive_tracker_top: mismatch");
        end
        $finish;
    end

endmodule
